[rtl/cursor_line_edit_buffer_assert.svh]
// Assertion macros used by the line editor top module.
`ifndef CURSOR_LINE_EDIT_BUFFER_ASSERT_SVH
`define CURSOR_LINE_EDIT_BUFFER_ASSERT_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define CLE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line editor check failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define CLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line editor check failed");

// The expression holds at every clock edge out of reset.
`define CLE_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("line editor check failed");

`endif

[rtl/cle_pkg.sv]
`default_nettype none
package cle_pkg;

  // Command codes of an input item.
  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_RIGHT  = 3'd2,
    CMD_BACK   = 3'd3,
    CMD_FLUSH  = 3'd4
  } cmd_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_SHIFT  = 2'd3
  } cell_op_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FLUSH = 1'b1
  } state_t;

  // Input item.
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] key_char;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       empty_res;
    logic       overflow;
  } out_item_t;

  // Control broadcast from the controller to the cells.
  typedef struct packed {
    cell_op_t   op;
    logic [7:0] key;
  } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/cle_cell.sv]
`default_nettype none
module cle_cell #(
  parameter int CAPACITY = 64,
  parameter int INDEX    = 0,
  parameter int PW       = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire cle_pkg::cell_ctl_t ctl,
  input  wire logic [PW-1:0]      cursor,
  input  wire logic [7:0]         left_char,
  input  wire logic [7:0]         right_char,
  output logic      [7:0]         char_out
);

  localparam logic [PW-1:0] IDX  = PW'(INDEX);
  localparam logic [PW-1:0] IDX1 = PW'(INDEX + 1);

  logic [7:0] char_r;
  logic [7:0] char_nxt;

  // Pick this cell's next character from the broadcast operation and its place
  // relative to the cursor.
  always_comb begin
    char_nxt = char_r;
    case (ctl.op)
      cle_pkg::CELL_INSERT: begin
        if (IDX > cursor) begin
          char_nxt = left_char;
        end else if (IDX == cursor) begin
          char_nxt = ctl.key;
        end
      end
      cle_pkg::CELL_DELETE: begin
        if (IDX1 >= cursor) begin
          char_nxt = right_char;
        end
      end
      cle_pkg::CELL_SHIFT: char_nxt = right_char;
      default:             char_nxt = char_r;
    endcase
  end

  // Character storage carries no reset.
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_out = char_r;

endmodule
`default_nettype wire

[rtl/cursor_line_edit_buffer.sv]
// Keystroke line editor. Insert, cursor left, cursor right and backspace each
// produce no result; start is taken again in the next cycle. A flush of a line
// holding L characters raises busy while the line drains and presents the
// characters in order, one per cycle, through the flush state and then the
// result register; the last one carries last and stands in the first
// cycle with busy low. A flush of an empty line presents one empty marker
// in the next cycle and does not raise busy. Every result stands on out_data
// for exactly one cycle with out_strobe high and must be captured then, since
// the receiver cannot stall the block. The flush rate is set by the row of
// character cells, which moves the line one cell toward the output per cycle.
`default_nettype none
module cursor_line_edit_buffer #(
  parameter int CAPACITY = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire cle_pkg::in_item_t in_data,
  output logic               out_strobe,
  output cle_pkg::out_item_t out_data
);

  `include "cursor_line_edit_buffer_assert.svh"

  localparam int PW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] CAP  = PW'(CAPACITY);
  localparam logic [PW-1:0] ONE  = PW'(1);
  localparam logic [PW-1:0] ZERO = '0;

  cle_pkg::state_t    state_r, state_nxt;
  logic [PW-1:0]      cursor_r, cursor_nxt;
  logic [PW-1:0]      length_r, length_nxt;
  logic [PW-1:0]      remain_r, remain_nxt;
  logic               ovf_seen_r, ovf_seen_nxt;
  logic               flush_ovf_r, flush_ovf_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  cle_pkg::out_item_t out_data_r, out_data_nxt;
  cle_pkg::cell_ctl_t ctl;
  logic               accept;
  logic [7:0]         cell_char [CAPACITY];

  assign busy   = (state_r == cle_pkg::ST_FLUSH);
  assign accept = start && !busy;

  // Controller: edit commands, flush sequencing and the result register.
  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    length_nxt     = length_r;
    remain_nxt     = remain_r;
    ovf_seen_nxt   = ovf_seen_r;
    flush_ovf_nxt  = flush_ovf_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    ctl.op         = cle_pkg::CELL_HOLD;
    ctl.key        = in_data.key_char;
    unique case (state_r)
      cle_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            cle_pkg::CMD_INSERT: begin
              if (length_r == CAP) begin
                ovf_seen_nxt = 1'b1;
              end else begin
                ctl.op     = cle_pkg::CELL_INSERT;
                cursor_nxt = cursor_r + ONE;
                length_nxt = length_r + ONE;
              end
            end
            cle_pkg::CMD_LEFT: begin
              if (cursor_r != ZERO) begin
                cursor_nxt = cursor_r - ONE;
              end
            end
            cle_pkg::CMD_RIGHT: begin
              if (cursor_r < length_r) begin
                cursor_nxt = cursor_r + ONE;
              end
            end
            cle_pkg::CMD_BACK: begin
              if (cursor_r != ZERO) begin
                ctl.op     = cle_pkg::CELL_DELETE;
                cursor_nxt = cursor_r - ONE;
                length_nxt = length_r - ONE;
              end
            end
            cle_pkg::CMD_FLUSH: begin
              if (length_r == ZERO) begin
                out_strobe_nxt         = 1'b1;
                out_data_nxt.out_char  = 8'h00;
                out_data_nxt.last      = 1'b1;
                out_data_nxt.empty_res = 1'b1;
                out_data_nxt.overflow  = ovf_seen_r;
              end else begin
                state_nxt     = cle_pkg::ST_FLUSH;
                remain_nxt    = length_r;
                flush_ovf_nxt = ovf_seen_r;
              end
              cursor_nxt   = ZERO;
              length_nxt   = ZERO;
              ovf_seen_nxt = 1'b0;
            end
            default: begin
              // Unused command codes leave everything as it is.
            end
          endcase
        end
      end
      cle_pkg::ST_FLUSH: begin
        ctl.op                 = cle_pkg::CELL_SHIFT;
        out_strobe_nxt         = 1'b1;
        out_data_nxt.out_char  = cell_char[0];
        out_data_nxt.last      = (remain_r == ONE);
        out_data_nxt.empty_res = 1'b0;
        out_data_nxt.overflow  = flush_ovf_r;
        remain_nxt             = remain_r - ONE;
        if (remain_r == ONE) begin
          state_nxt = cle_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cle_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cle_pkg::ST_IDLE;
      cursor_r     <= '0;
      length_r     <= '0;
      remain_r     <= '0;
      ovf_seen_r   <= 1'b0;
      flush_ovf_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_r     <= cursor_nxt;
      length_r     <= length_nxt;
      remain_r     <= remain_nxt;
      ovf_seen_r   <= ovf_seen_nxt;
      flush_ovf_r  <= flush_ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // Row of character cells; each trades with its neighbors, zero past an end.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] left_c;
    logic [7:0] right_c;
    if (g == 0) begin : g_first
      assign left_c = 8'h00;
    end else begin : g_mid_l
      assign left_c = cell_char[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_c = 8'h00;
    end else begin : g_mid_r
      assign right_c = cell_char[g+1];
    end
    cle_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g),
      .PW       (PW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cursor     (cursor_r),
      .left_char  (left_c),
      .right_char (right_c),
      .char_out   (cell_char[g])
    );
  end

  // Checks on controller consistency.
  `CLE_ASSERT_ALWAYS(a_cursor_in_line, cursor_r <= length_r)
  `CLE_ASSERT_ALWAYS(a_length_bound, length_r <= CAP)
  `CLE_ASSERT_SAME(a_flush_cleared, busy, (cursor_r == ZERO) && (length_r == ZERO))
  `CLE_ASSERT_SAME(a_empty_is_last, out_strobe && out_data.empty_res, out_data.last)
  `CLE_ASSERT_NEXT(a_flush_ends, busy && (remain_r == ONE), !busy && out_strobe && out_data.last)

endmodule
`default_nettype wire
